@@ hw/rtl/ps2md_pkg.sv @@
`default_nettype none

package ps2md_pkg;

	// action codes (s_tuser)
	localparam logic [1:0] ACT_COMMAND = 2'd0;
	localparam logic [1:0] ACT_MOTION  = 2'd1;
	localparam logic [1:0] ACT_FLUSH   = 2'd2;

	// host opcodes
	localparam logic [7:0] OP_RESET    = 8'hff;
	localparam logic [7:0] OP_SETRATE  = 8'hf3;
	localparam logic [7:0] OP_GETID    = 8'hf2;
	localparam logic [7:0] OP_DEFAULTS = 8'hf6;
	localparam logic [7:0] OP_SCALE1   = 8'he6;
	localparam logic [7:0] OP_SETRES   = 8'he8;
	localparam logic [7:0] OP_STREAM   = 8'hea;
	localparam logic [7:0] OP_ENABLE   = 8'hf4;
	localparam logic [7:0] OP_NOP      = 8'h00;

	// device replies
	localparam logic [7:0] RP_ACK     = 8'hfa;
	localparam logic [7:0] RP_NACK    = 8'hfe;
	localparam logic [7:0] RP_READY   = 8'haa;
	localparam logic [7:0] RP_ID_BASE = 8'h00;
	localparam logic [7:0] RP_ID_EXPL = 8'h04;

	// values loaded by the defaults command
	localparam logic [7:0] DEF_RATE = 8'd100;
	localparam logic [7:0] DEF_RES  = 8'd4;

	localparam int MAX_REPLIES = 4;
	localparam int CNT_W       = $clog2(MAX_REPLIES + 1);

	// s_tdata layout, lowest bit first: command_byte, link_ready, motion_valid,
	// left_button, right_button, delta_x, delta_y, wheel_step, zero fill
	typedef struct packed {
		logic [5:0]        pad;
		logic signed [3:0] wheel_step;
		logic signed [8:0] delta_y;
		logic signed [8:0] delta_x;
		logic              right_button;
		logic              left_button;
		logic              motion_valid;
		logic              link_ready;
		logic [7:0]        command_byte;
	} item_t;

endpackage

`default_nettype wire

@@ hw/rtl/ps2_mouse_device_responder.sv @@
`default_nettype none

// Device side of a PS/2 wheel mouse (Explorer-style ID 4). Each input
// transaction carries an action in s_tuser: a host command byte, a motion
// report or a queue flush. Commands are answered with zero to three reply
// bytes, a motion report while reporting is enabled gives a 4-byte packet,
// and a flush drops any half-done two-byte command and a pending enable.
// Every reply byte leaves as one output transaction, with m_tlast set on
// the final byte caused by an input. An accepted input is held in the
// input register, then is decoded into a four-entry reply buffer that
// drains one byte per cycle while m_tready is high; the next input is
// decoded in the same cycle as the previous run's last byte is taken, and
// one more input can wait in the input register meanwhile. Throughput is
// thus set by the single-byte output port. Between input and first reply
// byte lie the input register and the reply buffer. Enable arms reporting
// only; it takes effect after the next motion report has been handled.
module ps2_mouse_device_responder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] command_byte, [8] link_ready, [9] motion_valid, [10] left_button,
	// [11] right_button, [20:12] delta_x, [29:21] delta_y, [33:30] wheel_step
	input  wire logic [39:0] s_tdata,
	// [1:0] action
	input  wire logic [1:0]  s_tuser,
	// reply stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] reply_byte
	output logic [7:0]       m_tdata,
	output logic             m_tlast
);

	// input register
	logic                  valid_s1;
	ps2md_pkg::item_t      item_s1;
	logic [1:0]            action_s1;

	// reply buffer: entry 0 is on the port
	logic [7:0]            reply_q [ps2md_pkg::MAX_REPLIES];
	logic [ps2md_pkg::CNT_W-1:0] count_q;

	// device state
	logic [7:0] pending_cmd_q;
	logic       pending_valid_q;
	logic       command_acked_q;
	logic [7:0] sample_rate_q;
	logic [7:0] resolution_q;
	logic       stream_mode_q;
	logic       enable_armed_q;
	logic       reporting_en_q;

	// decode results
	logic [7:0] rep [ps2md_pkg::MAX_REPLIES];
	logic [ps2md_pkg::CNT_W-1:0] rep_cnt;
	logic [7:0] pending_cmd_d;
	logic       pending_valid_d;
	logic       command_acked_d;
	logic [7:0] sample_rate_d;
	logic [7:0] resolution_d;
	logic       stream_mode_d;
	logic       enable_armed_d;
	logic       reporting_en_d;

	logic       buf_free;
	logic       load;
	logic       out_fire;
	logic [8:0] neg_dy;

	assign out_fire = m_tvalid && m_tready;
	// buffer can take a new run once the last byte of the current run is leaving
	assign buf_free = (count_q == '0) ||
		((count_q == ps2md_pkg::CNT_W'(1)) && m_tready);
	assign load     = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || buf_free;

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = reply_q[0];
	assign m_tlast  = (count_q == ps2md_pkg::CNT_W'(1));

	assign neg_dy = 9'd0 - item_s1.delta_y;

	// decode of the registered item against the current state
	always_comb begin
		for (int i = 0; i < ps2md_pkg::MAX_REPLIES; i++) begin
			rep[i] = ps2md_pkg::RP_ACK;
		end
		rep_cnt         = '0;
		pending_cmd_d   = pending_cmd_q;
		pending_valid_d = pending_valid_q;
		command_acked_d = command_acked_q;
		sample_rate_d   = sample_rate_q;
		resolution_d    = resolution_q;
		stream_mode_d   = stream_mode_q;
		enable_armed_d  = enable_armed_q;
		reporting_en_d  = reporting_en_q;

		case (action_s1)
			ps2md_pkg::ACT_COMMAND: begin
				if (pending_valid_q) begin
					// argument byte of set-rate / set-resolution
					if (pending_cmd_q == ps2md_pkg::OP_SETRATE) begin
						sample_rate_d = item_s1.command_byte;
					end else begin
						resolution_d = item_s1.command_byte;
					end
					pending_valid_d = 1'b0;
					pending_cmd_d   = '0;
					rep_cnt         = ps2md_pkg::CNT_W'(1);
				end else begin
					command_acked_d = 1'b1;
					case (item_s1.command_byte)
						ps2md_pkg::OP_RESET: begin
							rep[1]  = ps2md_pkg::RP_READY;
							rep[2]  = ps2md_pkg::RP_ID_BASE;
							rep_cnt = ps2md_pkg::CNT_W'(3);
						end
						ps2md_pkg::OP_DEFAULTS: begin
							sample_rate_d  = ps2md_pkg::DEF_RATE;
							resolution_d   = ps2md_pkg::DEF_RES;
							enable_armed_d = 1'b0;
							reporting_en_d = 1'b0;
							rep_cnt        = ps2md_pkg::CNT_W'(1);
						end
						ps2md_pkg::OP_SETRATE, ps2md_pkg::OP_SETRES: begin
							pending_cmd_d   = item_s1.command_byte;
							pending_valid_d = 1'b1;
							rep_cnt         = ps2md_pkg::CNT_W'(1);
						end
						ps2md_pkg::OP_GETID: begin
							rep[0]  = ps2md_pkg::RP_ID_EXPL;
							rep_cnt = ps2md_pkg::CNT_W'(1);
						end
						ps2md_pkg::OP_SCALE1, ps2md_pkg::OP_NOP: begin
							rep_cnt = ps2md_pkg::CNT_W'(1);
						end
						ps2md_pkg::OP_STREAM: begin
							stream_mode_d = 1'b1;
							rep_cnt       = ps2md_pkg::CNT_W'(1);
						end
						ps2md_pkg::OP_ENABLE: begin
							enable_armed_d = 1'b1;
							reporting_en_d = 1'b0;
							rep[0]  = item_s1.link_ready ? ps2md_pkg::RP_ACK
							                             : ps2md_pkg::RP_NACK;
							rep_cnt = ps2md_pkg::CNT_W'(1);
						end
						default: begin
							// unknown opcode: silent, not acked
							command_acked_d = 1'b0;
						end
					endcase
				end
			end
			ps2md_pkg::ACT_MOTION: begin
				if (reporting_en_q && item_s1.motion_valid) begin
					rep[0] = {2'b00,
						(!item_s1.delta_y[8]) && (item_s1.delta_y != 9'd0),
						item_s1.delta_x[8],
						1'b1, 1'b0,
						item_s1.right_button,
						item_s1.left_button};
					rep[1] = item_s1.delta_x[7:0];
					rep[2] = neg_dy[7:0];
					if (item_s1.wheel_step == 4'sd1) begin
						rep[3] = 8'h01;
					end else if (item_s1.wheel_step == -4'sd1) begin
						rep[3] = 8'h0f;
					end else begin
						rep[3] = 8'h00;
					end
					rep_cnt = ps2md_pkg::CNT_W'(4);
				end
				// armed enable goes live after this report
				if (enable_armed_q) begin
					enable_armed_d = 1'b0;
					reporting_en_d = 1'b1;
				end
			end
			ps2md_pkg::ACT_FLUSH: begin
				pending_valid_d = 1'b0;
				pending_cmd_d   = '0;
				command_acked_d = 1'b0;
				enable_armed_d  = 1'b0;
			end
			default: begin
				// reserved action: ignored
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			count_q         <= '0;
			pending_cmd_q   <= '0;
			pending_valid_q <= 1'b0;
			command_acked_q <= 1'b0;
			sample_rate_q   <= '0;
			resolution_q    <= '0;
			stream_mode_q   <= 1'b0;
			enable_armed_q  <= 1'b0;
			reporting_en_q  <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (load) begin
				count_q         <= rep_cnt;
				pending_cmd_q   <= pending_cmd_d;
				pending_valid_q <= pending_valid_d;
				command_acked_q <= command_acked_d;
				sample_rate_q   <= sample_rate_d;
				resolution_q    <= resolution_d;
				stream_mode_q   <= stream_mode_d;
				enable_armed_q  <= enable_armed_d;
				reporting_en_q  <= reporting_en_d;
			end else if (out_fire) begin
				count_q <= count_q - ps2md_pkg::CNT_W'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1   <= ps2md_pkg::item_t'(s_tdata);
			action_s1 <= s_tuser;
		end
		if (load) begin
			for (int i = 0; i < ps2md_pkg::MAX_REPLIES; i++) begin
				reply_q[i] <= rep[i];
			end
		end else if (out_fire) begin
			for (int i = 0; i < ps2md_pkg::MAX_REPLIES - 1; i++) begin
				reply_q[i] <= reply_q[i+1];
			end
		end
	end

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ps2md_pkg::CNT_W'(ps2md_pkg::MAX_REPLIES))
		else $error("reply count out of range");

	a_pending_op: assert property (@(posedge clk) disable iff (!arst_n)
		pending_valid_q |-> ((pending_cmd_q == ps2md_pkg::OP_SETRATE) ||
		                     (pending_cmd_q == ps2md_pkg::OP_SETRES)) && command_acked_q)
		else $error("pending command is not an acked two-byte opcode");

	a_arm_excl: assert property (@(posedge clk) disable iff (!arst_n)
		enable_armed_q |-> !reporting_en_q)
		else $error("enable armed while reporting already enabled");

	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (rep_cnt != '0)) |=> m_tvalid)
		else $error("decoded replies not presented");

	a_stream_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stream_mode_q |=> stream_mode_q)
		else $error("stream mode cleared");

endmodule

`default_nettype wire
